// ===== hw/rtl/scc_pkg.sv =====
// scc_pkg: shared constants, types and helpers of the sector cache tag engine
// used by scc_tag_ram, scc_slot_flags and sector_cache_clock_replacement
`default_nettype none

package scc_pkg;

    localparam int ENTRIES     = 64;
    localparam int SECTOR_BITS = 32;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int SECTOR_W    = 32;   // width of the sector port field
    localparam int SLOT_W      = 6;    // width of the slot port field
    localparam int OUTCOME_W   = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [SECTOR_BITS-1:0] t_tag;

    // operations on the per-slot flag bits and the clock hand
    typedef enum logic [2:0] {
        FOP_NONE,
        FOP_CLR_ACC,
        FOP_CLR_DIRTY,
        FOP_TOUCH,
        FOP_INSTALL,
        FOP_SET_HAND
    } t_flag_op;

    typedef struct packed {
        t_flag_op op;
        t_idx     idx;
        logic     wr;
    } t_flag_cmd;

    typedef struct packed {
        logic valid;
        logic accessed;
        logic dirty;
        t_idx hand;
    } t_flag_rd;

    // slot after n, wrapping at the last slot
    function automatic t_idx next_slot(input t_idx n);
        t_idx r;
        if (n == LAST_IDX) begin
            r = '0;
        end else begin
            r = n + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scc_tag_ram.sv =====
// scc_tag_ram: tag store of the sector cache, one write and one read port
// depends on scc_pkg
`default_nettype none

module scc_tag_ram
    import scc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_we,
    input  wire t_idx i_waddr,
    input  wire t_tag i_wdata,
    input  wire t_idx i_raddr,
    output t_tag      o_rdata
);

    t_tag r_mem [ENTRIES];
    t_tag r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/scc_slot_flags.sv =====
// scc_slot_flags: valid, accessed and dirty bits of every slot plus the clock hand
// depends on scc_pkg
`default_nettype none

module scc_slot_flags
    import scc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_flag_cmd i_cmd,
    input  wire t_idx      i_rd_idx,
    output t_flag_rd       o_rd
);

    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_acc;
    logic [ENTRIES-1:0] r_dirty;
    t_idx               r_hand;

    // flag updates, one slot per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_acc   <= '0;
            r_dirty <= '0;
            r_hand  <= '0;
        end else begin
            unique case (i_cmd.op)
                FOP_NONE: begin
                end
                FOP_CLR_ACC: begin
                    r_acc[i_cmd.idx] <= 1'b0;
                end
                FOP_CLR_DIRTY: begin
                    r_dirty[i_cmd.idx] <= 1'b0;
                end
                FOP_TOUCH: begin
                    r_acc[i_cmd.idx] <= 1'b1;
                    if (i_cmd.wr) begin
                        r_dirty[i_cmd.idx] <= 1'b1;
                    end
                end
                FOP_INSTALL: begin
                    r_valid[i_cmd.idx] <= 1'b1;
                    r_acc[i_cmd.idx]   <= 1'b1;
                    r_dirty[i_cmd.idx] <= i_cmd.wr;
                end
                FOP_SET_HAND: begin
                    r_hand <= i_cmd.idx;
                end
                default: begin
                end
            endcase
        end
    end

    // read of the selected slot
    assign o_rd.valid    = r_valid[i_rd_idx];
    assign o_rd.accessed = r_acc[i_rd_idx];
    assign o_rd.dirty    = r_dirty[i_rd_idx];
    assign o_rd.hand     = r_hand;

endmodule

`default_nettype wire

// ===== hw/rtl/sector_cache_clock_replacement.sv =====
// sector_cache_clock_replacement: top level of the sector cache tag and replacement engine
// depends on scc_pkg, scc_tag_ram, scc_slot_flags
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   i_cmd, i_sector
//   output   out        o_valid / i_stall   o_slot, o_outcome, o_fill_needed,
//                                           o_writeback_needed, o_victim_sector
//
// one transaction at a time; the tag scan reads one slot per cycle from the tag ram
// a hit ends the scan at the matching slot; a miss scans every slot, then fills the first empty one
// an eviction adds a clock sweep, one step per cycle, then a read of the victim tag
// o_stall is high whenever the sequencer is busy; a stalled result holds the update
// reset clears all slot flags and the hand; the tag ram needs no clearing
`default_nettype none

module sector_cache_clock_replacement
    import scc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_cmd,
    input  wire logic [SECTOR_W-1:0]  i_sector,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [SLOT_W-1:0]         o_slot,
    output logic [OUTCOME_W-1:0]      o_outcome,
    output logic                      o_fill_needed,
    output logic                      o_writeback_needed,
    output logic [SECTOR_W-1:0]       o_victim_sector
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SWEEP,
        S_VREAD,
        S_VCAP,
        S_UPDATE
    } t_state;

    t_state                r_state;
    logic                  r_wr;
    t_tag                  r_sector;
    t_idx                  r_cnt;
    t_idx                  r_pidx;
    logic                  r_rd_vld;
    logic                  r_have_empty;
    t_idx                  r_empty;
    t_idx                  r_ptr;
    logic                  r_pass;
    t_idx                  r_slot;
    logic [OUTCOME_W-1:0]  r_outcome;
    t_tag                  r_victim;

    logic                  r_ovld;
    logic [SLOT_W-1:0]     r_oslot;
    logic [OUTCOME_W-1:0]  r_ooutcome;
    logic                  r_ofill;
    logic                  r_owb;
    logic [SECTOR_W-1:0]   r_ovictim;

    t_flag_cmd             flag_cmd;
    t_flag_rd              flag_rd;
    t_idx                  flag_idx;
    t_idx                  ram_raddr;
    t_tag                  ram_rdata;
    logic                  ram_we;
    logic                  out_free;
    logic                  tag_hit;
    logic                  sweep_take;
    t_idx                  hand_next;

    assign o_stall   = (r_state != S_IDLE);
    assign out_free  = !r_ovld || !i_stall;
    assign tag_hit   = r_rd_vld && flag_rd.valid && (ram_rdata == r_sector);
    assign hand_next = next_slot(flag_rd.hand);
    assign sweep_take = (r_ptr != flag_rd.hand) && !flag_rd.accessed && !flag_rd.dirty;
    assign flag_idx  = (r_state == S_SWEEP) ? r_ptr : r_pidx;
    assign ram_raddr = (r_state == S_VREAD) ? r_slot : r_cnt;
    assign ram_we    = (r_state == S_UPDATE) && out_free && (r_outcome != OUT_HIT);

    // flag command from the sequencer
    always_comb begin
        flag_cmd.op  = FOP_NONE;
        flag_cmd.idx = r_ptr;
        flag_cmd.wr  = r_wr;
        priority case (r_state)
            S_SWEEP: begin
                if (r_ptr == flag_rd.hand) begin
                    if (r_pass) begin
                        flag_cmd.op  = FOP_SET_HAND;
                        flag_cmd.idx = hand_next;
                    end
                end else if (sweep_take) begin
                    flag_cmd.op = FOP_SET_HAND;
                end else begin
                    flag_cmd.op = r_pass ? FOP_CLR_DIRTY : FOP_CLR_ACC;
                end
            end
            S_UPDATE: begin
                flag_cmd.idx = r_slot;
                if (out_free) begin
                    flag_cmd.op = (r_outcome == OUT_HIT) ? FOP_TOUCH : FOP_INSTALL;
                end
            end
            default: begin
            end
        endcase
    end

    scc_tag_ram u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_sector),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    scc_slot_flags u_slot_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (flag_cmd),
        .i_rd_idx(flag_idx),
        .o_rd    (flag_rd)
    );

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovld   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (r_ovld && !i_stall) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_wr         <= i_cmd;
                        r_sector     <= SECTOR_BITS'(i_sector);
                        r_cnt        <= '0;
                        r_rd_vld     <= 1'b0;
                        r_have_empty <= 1'b0;
                        r_victim     <= '0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue the next tag read while comparing the previous one
                    if (r_cnt != LAST_IDX) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_pidx   <= r_cnt;
                    r_rd_vld <= 1'b1;
                    if (tag_hit) begin
                        r_slot    <= r_pidx;
                        r_outcome <= OUT_HIT;
                        r_state   <= S_UPDATE;
                    end else if (r_rd_vld) begin
                        if (!flag_rd.valid && !r_have_empty) begin
                            r_have_empty <= 1'b1;
                            r_empty      <= r_pidx;
                        end
                        if (r_pidx == LAST_IDX) begin
                            if (r_have_empty) begin
                                r_slot    <= r_empty;
                                r_outcome <= OUT_FILL;
                                r_state   <= S_UPDATE;
                            end else if (!flag_rd.valid) begin
                                r_slot    <= r_pidx;
                                r_outcome <= OUT_FILL;
                                r_state   <= S_UPDATE;
                            end else begin
                                r_ptr     <= hand_next;
                                r_pass    <= 1'b0;
                                r_outcome <= OUT_EVICT;
                                r_state   <= S_SWEEP;
                            end
                        end
                    end
                end
                S_SWEEP: begin
                    // one slot of the clock sweep per cycle
                    if (r_ptr == flag_rd.hand) begin
                        if (r_pass) begin
                            r_slot  <= hand_next;
                            r_state <= S_VREAD;
                        end else begin
                            r_pass <= 1'b1;
                            r_ptr  <= hand_next;
                        end
                    end else if (sweep_take) begin
                        r_slot  <= r_ptr;
                        r_state <= S_VREAD;
                    end else begin
                        r_ptr <= next_slot(r_ptr);
                    end
                end
                S_VREAD: begin
                    r_state <= S_VCAP;
                end
                S_VCAP: begin
                    r_victim <= ram_rdata;
                    r_state  <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (out_free) begin
                        r_ovld     <= 1'b1;
                        r_oslot    <= SLOT_W'(r_slot);
                        r_ooutcome <= r_outcome;
                        r_ofill    <= (r_outcome != OUT_HIT);
                        r_owb      <= (r_outcome == OUT_EVICT);
                        r_ovictim  <= SECTOR_W'(r_victim);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = r_ovld;
    assign o_slot             = r_oslot;
    assign o_outcome          = r_ooutcome;
    assign o_fill_needed      = r_ofill;
    assign o_writeback_needed = r_owb;
    assign o_victim_sector    = r_ovictim;

endmodule

`default_nettype wire
